// ===== design/mhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhp_pkg;

    localparam int SLOT_COUNT_W = 9;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 9'd32;

    typedef enum logic [2:0] {
        CMD_READ        = 3'd0,
        CMD_WRITE       = 3'd1,
        CMD_PLUG        = 3'd2,
        CMD_UNPLUG_REQ  = 3'd3,
        CMD_UNPLUG_DONE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_SEL   = 2'd1,
        STS_EJECT_OFF = 2'd2,
        STS_BAD_EVENT = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // register window offsets
    localparam logic [7:0] OFF_BASE_LO = 8'h00;
    localparam logic [7:0] OFF_BASE_HI = 8'h04;
    localparam logic [7:0] OFF_SIZE_LO = 8'h08;
    localparam logic [7:0] OFF_SIZE_HI = 8'h0c;
    localparam logic [7:0] OFF_NODE    = 8'h10;
    localparam logic [7:0] OFF_FLAGS   = 8'h14;

    // write aliases of the same offsets
    localparam logic [7:0] OFF_SELECTOR  = 8'h00;
    localparam logic [7:0] OFF_OST_EVENT = 8'h04;
    localparam logic [7:0] OFF_OST_STAT  = 8'h08;

    localparam int FLAG_ENABLED   = 0;
    localparam int FLAG_INSERTING = 1;
    localparam int FLAG_REMOVING  = 2;
    localparam int FLAG_EJECT     = 3;

    localparam logic [31:0] READ_UNKNOWN = '1;

    // last field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic        can_hotplug;
        logic        is_hot;
        logic [31:0] dimm_node;
        logic [63:0] dimm_size;
        logic [63:0] dimm_address;
        logic [7:0]  event_slot;
        logic [31:0] write_data;
        logic [7:0]  reg_offset;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  pad;
        status_t     status;
        logic [31:0] ost_code;
        logic [31:0] ost_source;
        logic [7:0]  ost_slot;
        logic        ost_report;
        logic [7:0]  eject_slot;
        logic        eject_request;
        logic        notify;
        logic [31:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [31:0] dimm_node;
        logic [63:0] dimm_size;
        logic [63:0] dimm_address;
    } slot_data_t;

endpackage

`default_nettype wire

// ===== design/mhp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/memory_hotplug_slot_registers.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                              | carries
// ----------+------------------------------------+--------------------------------------
// request   | s_tvalid s_tready s_tdata s_tuser  | bus read/write or plug/unplug event
// result    | m_tvalid m_tready m_tdata          | read data, notify, eject, ost report
// config    | cfg_wen cfg_wdata                  | slot_count
//
// each request is taken in S_IDLE, where the slot memories are read at the selector,
// and is formed into a result and written back in S_EXEC; a new request is taken only
// in S_IDLE. the result register lets a request enter while the last result
// waits; a stalled result holds the block in S_EXEC.
// synchronous reset clears selector, slot flags and ost valid bits; slot_count
// returns to 32.
module memory_hotplug_slot_registers
    import mhp_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // reg_offset, write_data, event_slot, dimm_address, dimm_size, dimm_node,
    // is_hot, can_hotplug
    input  wire logic [215:0]              s_tdata,
    // cmd
    input  wire logic [7:0]                s_tuser,

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // read_data, notify, eject_request, eject_slot, ost_report, ost_slot,
    // ost_source, ost_code, status
    output logic [119:0]                   m_tdata,

    input  wire logic                      cfg_wen,
    input  wire logic [SLOT_COUNT_W-1:0]   cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_COUNT_W-1:0] SLOTS_MAX = SLOT_COUNT_W'(SLOTS);

    state_t                  state_reg, state_next;
    logic [SLOT_COUNT_W-1:0] slot_count_reg;
    logic [31:0]             sel_reg, sel_next;
    in_item_t                item_reg;
    cmd_t                    cmd_reg;
    out_item_t               out_reg, out_next;
    logic                    m_valid_reg, m_valid_next;

    logic [SLOTS-1:0]        en_reg, ins_reg, rem_reg, ost_vld_reg;

    logic                    s_fire;
    logic                    exec_go;
    logic [SLOT_COUNT_W-1:0] n_used;
    logic                    sel_ok, ev_ok;
    logic [IDX_W-1:0]        sel_idx, ev_idx;
    slot_data_t              dimm_rd, dimm_wr;
    logic [31:0]             ost_rd, ost_src_word;
    logic                    sel_en, sel_ins, sel_rem;

    logic                    upd_ost, upd_plug, upd_clr_ins, upd_clr_rem;
    logic                    upd_set_rem, upd_clr_en;

    assign s_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign exec_go = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    assign n_used  = (slot_count_reg > SLOTS_MAX) ? SLOTS_MAX : slot_count_reg;
    assign sel_ok  = sel_reg < {{(32-SLOT_COUNT_W){1'b0}}, n_used};
    assign ev_ok   = {1'b0, item_reg.event_slot} < n_used;
    assign sel_idx = sel_reg[IDX_W-1:0];
    assign ev_idx  = item_reg.event_slot[IDX_W-1:0];

    assign sel_en  = en_reg[sel_idx];
    assign sel_ins = ins_reg[sel_idx];
    assign sel_rem = rem_reg[sel_idx];
    assign ost_src_word = ost_vld_reg[sel_idx] ? ost_rd : 32'd0;

    assign dimm_wr.dimm_node    = item_reg.dimm_node;
    assign dimm_wr.dimm_size    = item_reg.dimm_size;
    assign dimm_wr.dimm_address = item_reg.dimm_address;

    // base, size and node of each slot; read at the selector, written on plug
    mhp_ram #(
        .WIDTH ($bits(slot_data_t)),
        .DEPTH (SLOTS)
    ) u_dimm_ram (
        .clk   (aclk),
        .we    (upd_plug),
        .waddr (ev_idx),
        .wdata (dimm_wr),
        .re    (s_fire),
        .raddr (sel_idx),
        .rdata (dimm_rd)
    );

    // ost event word per slot; the status word is only forwarded on the report
    mhp_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_ost_ram (
        .clk   (aclk),
        .we    (upd_ost),
        .waddr (sel_idx),
        .wdata (item_reg.write_data),
        .re    (s_fire),
        .raddr (sel_idx),
        .rdata (ost_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_fire) state_next = S_EXEC;
            S_EXEC: if (exec_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        sel_next    = sel_reg;
        upd_ost     = 1'b0;
        upd_plug    = 1'b0;
        upd_clr_ins = 1'b0;
        upd_clr_rem = 1'b0;
        upd_set_rem = 1'b0;
        upd_clr_en  = 1'b0;

        if (exec_go) begin
            m_valid_next = 1'b1;
            out_next     = '0;
            out_next.status = STS_OK;
            unique case (cmd_reg)
                CMD_READ: begin
                    if (!sel_ok) begin
                        out_next.status = STS_BAD_SEL;
                    end else begin
                        unique case (item_reg.reg_offset)
                            OFF_BASE_LO: out_next.read_data =
                                sel_en ? dimm_rd.dimm_address[31:0] : 32'd0;
                            OFF_BASE_HI: out_next.read_data =
                                sel_en ? dimm_rd.dimm_address[63:32] : 32'd0;
                            OFF_SIZE_LO: out_next.read_data =
                                sel_en ? dimm_rd.dimm_size[31:0] : 32'd0;
                            OFF_SIZE_HI: out_next.read_data =
                                sel_en ? dimm_rd.dimm_size[63:32] : 32'd0;
                            OFF_NODE:    out_next.read_data =
                                sel_en ? dimm_rd.dimm_node : 32'd0;
                            OFF_FLAGS:   out_next.read_data =
                                {29'd0, sel_rem, sel_ins, sel_en};
                            default:     out_next.read_data = READ_UNKNOWN;
                        endcase
                    end
                end
                CMD_WRITE: begin
                    if (n_used != '0) begin
                        priority if (item_reg.reg_offset == OFF_SELECTOR) begin
                            sel_next = item_reg.write_data;
                        end else if (!sel_ok) begin
                            out_next.status = STS_BAD_SEL;
                        end else if (item_reg.reg_offset == OFF_OST_EVENT) begin
                            upd_ost = 1'b1;
                        end else if (item_reg.reg_offset == OFF_OST_STAT) begin
                            out_next.ost_report = 1'b1;
                            out_next.ost_slot   = sel_reg[7:0];
                            out_next.ost_source = ost_src_word;
                            out_next.ost_code   = item_reg.write_data;
                        end else if (item_reg.reg_offset == OFF_FLAGS) begin
                            priority if (item_reg.write_data[FLAG_INSERTING]) begin
                                upd_clr_ins = 1'b1;
                            end else if (item_reg.write_data[FLAG_REMOVING]) begin
                                upd_clr_rem = 1'b1;
                            end else if (item_reg.write_data[FLAG_EJECT]) begin
                                if (!sel_en) begin
                                    out_next.status = STS_EJECT_OFF;
                                end else begin
                                    out_next.eject_request = 1'b1;
                                    out_next.eject_slot    = sel_reg[7:0];
                                end
                            end else begin
                                // no flag action requested
                            end
                        end else begin
                            // other offsets are ignored
                        end
                    end
                end
                CMD_PLUG: begin
                    if (item_reg.can_hotplug) begin
                        if (!ev_ok) begin
                            out_next.status = STS_BAD_EVENT;
                        end else begin
                            upd_plug       = 1'b1;
                            out_next.notify = item_reg.is_hot;
                        end
                    end
                end
                CMD_UNPLUG_REQ: begin
                    if (!ev_ok) begin
                        out_next.status = STS_BAD_EVENT;
                    end else begin
                        upd_set_rem     = 1'b1;
                        out_next.notify = 1'b1;
                    end
                end
                CMD_UNPLUG_DONE: begin
                    if (!ev_ok) begin
                        out_next.status = STS_BAD_EVENT;
                    end else begin
                        upd_clr_en = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SLOT_COUNT_RST;
            sel_reg        <= '0;
            m_valid_reg    <= 1'b0;
            en_reg         <= '0;
            ins_reg        <= '0;
            rem_reg        <= '0;
            ost_vld_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                slot_count_reg <= cfg_wdata;
            end
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            if (upd_ost) begin
                ost_vld_reg[sel_idx] <= 1'b1;
            end
            if (upd_clr_ins) begin
                ins_reg[sel_idx] <= 1'b0;
            end
            if (upd_clr_rem) begin
                rem_reg[sel_idx] <= 1'b0;
            end
            if (upd_plug) begin
                en_reg[ev_idx] <= 1'b1;
                if (item_reg.is_hot) begin
                    ins_reg[ev_idx] <= 1'b1;
                end
            end
            if (upd_set_rem) begin
                rem_reg[ev_idx] <= 1'b1;
            end
            if (upd_clr_en) begin
                en_reg[ev_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= in_item_t'(s_tdata);
            cmd_reg  <= cmd_t'(s_tuser[2:0]);
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire
